### rtl/core/pq_int4_adc_distance_assert.svh
// Assertion macros shared by the distance block's top level and merge stage.
`ifndef PQ_INT4_ADC_DISTANCE_ASSERT_SVH
`define PQ_INT4_ADC_DISTANCE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge of clk, suspended while rst is high.
`define PQADC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define PQADC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PQADC_ASSERT(lbl, prop, msg)
`define PQADC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### rtl/core/pqadc_pkg.sv
// Shared types and constants of the 4-bit product-quantization distance block.
package pqadc_pkg;

  // Field widths.
  localparam int CMD_W     = 1;
  localparam int INDEX_W   = 12;
  localparam int VALUE_W   = 32;
  localparam int WORD_W    = 64;
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 9;

  // Code geometry: 16 nibbles per word, 16 centroids per subspace.
  localparam int CODE_W    = 4;
  localparam int CENTROIDS = 16;
  localparam int LANES     = 16;
  localparam int LANE_W    = 4;

  // Defaults.
  localparam int MAX_SUBSPACES_DEF = 256;
  localparam logic [CFG_W-1:0] NUM_SUBSPACES_RST = CFG_W'(16);

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 1'b0,
    CMD_CODE  = 1'b1
  } cmd_t;

  // Per-lane bank control for one cycle.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic use_entry;
  } lane_ctl_t;

  // A code word leaving the lane stage.
  typedef struct packed {
    logic valid;
    logic last;
  } word_ctl_t;

endpackage

### rtl/core/pqadc_req_if.sv
// Input channel: table writes and candidate code words.
interface pqadc_req_if import pqadc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  cmd_t                      command;
  logic [INDEX_W-1:0]        table_index;
  logic signed [VALUE_W-1:0] table_value;
  logic [WORD_W-1:0]         code_word;

  modport source (output valid, command, table_index, table_value, code_word,
                  input ready);
  modport sink (input valid, command, table_index, table_value, code_word,
                output ready);
endinterface

### rtl/core/pqadc_res_if.sv
// Output channel: one distance per candidate.
interface pqadc_res_if import pqadc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

### rtl/core/pqadc_cfg_if.sv
// Configuration channel: writes the subspace count.
interface pqadc_cfg_if import pqadc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_subspaces;

  modport source (output valid, num_subspaces, input ready);
  modport sink (input valid, num_subspaces, output ready);
endinterface

### rtl/core/pq_int4_adc_distance.sv
// Top level of the 4-bit product-quantization asymmetric distance block.
// A result passes the lane read register, both adder tree levels and the output register.
// Throughput: one item per cycle (table write or code word) unless a stall holds input; 16 banks read in parallel.
// A waiting result stalls input only after the three internal stages have filled.
// Reset clears the pipeline, the partial sum and the word count and sets 16 subspaces.
`include "pq_int4_adc_distance_assert.svh"
module pq_int4_adc_distance import pqadc_pkg::*; #(
  parameter int MAX_SUBSPACES = MAX_SUBSPACES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pqadc_cfg_if.sink   cfg,
  pqadc_req_if.sink   req,
  pqadc_res_if.source res
);

  localparam int WORDS_MAX  = (MAX_SUBSPACES + LANES - 1) / LANES;
  localparam int WCW        = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int BANK_DEPTH = WORDS_MAX * CENTROIDS;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int NW         = $clog2(MAX_SUBSPACES + 1);
  localparam int LUT_DEPTH  = MAX_SUBSPACES * CENTROIDS;

  logic [CFG_W-1:0]          num_subspaces;
  logic [NW-1:0]             n_eff;
  logic [NW-1:0]             nm1;
  logic [WCW-1:0]            last_word;
  logic [CODE_W-1:0]         tail;
  logic [WCW-1:0]            word_count;
  logic [WCW-1:0]            word_count_next;
  logic                      is_last;
  logic                      acc_write;
  logic                      acc_code;
  logic                      wr_ok;
  logic                      lv;
  logic                      l_last;
  logic                      word_ready;
  logic [AW-1:0]             waddr;
  lane_ctl_t                 lane_ctl [LANES];
  logic signed [VALUE_W-1:0] lane_val [LANES];
  word_ctl_t                 word;

  // Configuration register; the user must write it only while the block is idle; the block itself does not enforce it.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_subspaces <= NUM_SUBSPACES_RST;
    end else if (cfg.valid) begin
      num_subspaces <= cfg.num_subspaces;
    end
  end

  // Effective count: zero acts as one, large values saturate.
  always_comb begin
    if (num_subspaces == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_subspaces) > MAX_SUBSPACES) begin
      n_eff = NW'(MAX_SUBSPACES);
    end else begin
      n_eff = NW'(num_subspaces);
    end
  end

  assign nm1       = n_eff - NW'(1);
  assign last_word = WCW'(nm1 >> LANE_W);
  assign tail      = nm1[CODE_W-1:0];

  // Input handshake; the lane stage takes a word when it has room.
  assign req.ready = !lv || word_ready;
  assign acc_write = req.valid && req.ready && (req.command == CMD_WRITE);
  assign acc_code  = req.valid && req.ready && (req.command == CMD_CODE);
  assign wr_ok     = 32'(req.table_index) < LUT_DEPTH;
  assign waddr     = AW'({req.table_index[INDEX_W-1:CODE_W+LANE_W],
                          req.table_index[CODE_W-1:0]});

  // Word position within the candidate.
  assign is_last         = word_count >= last_word;
  assign word_count_next = is_last ? '0 : word_count + WCW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (acc_code) begin
      word_count <= word_count_next;
    end
  end

  // Lane stage control: a word sits here while its bank reads are registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= 1'b0;
    end else if (req.ready) begin
      lv <= acc_code;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_code) begin
      l_last <= is_last;
    end
  end

  // Sixteen lanes, each owning one nibble position of the code word.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign lane_ctl[k].wr_en = acc_write && wr_ok
        && (req.table_index[CODE_W +: LANE_W] == LANE_W'(k));
    assign lane_ctl[k].rd_en = acc_code;
    assign lane_ctl[k].use_entry = (word_count < last_word)
        || ((word_count == last_word) && (CODE_W'(k) <= tail));

    pqadc_lane #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_lane (
      .clk   (clk),
      .ctl   (lane_ctl[k]),
      .waddr (waddr),
      .wdata (req.table_value),
      .raddr (AW'({word_count, req.code_word[k*CODE_W +: CODE_W]})),
      .value (lane_val[k])
    );
  end

  // Adder tree and accumulator.
  assign word.valid = lv;
  assign word.last  = l_last;

  pqadc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .word       (word),
    .word_ready (word_ready),
    .lane_val   (lane_val),
    .res        (res)
  );

  `PQADC_ASSERT(a_wc_wrap, acc_code && is_last |=> word_count == '0, "word count not cleared at candidate end")
  `PQADC_ASSERT(a_wc_step, acc_code && !is_last |=> word_count == WCW'($past(word_count) + WCW'(1)), "word count did not advance")
  `PQADC_ASSERT(a_lane_hold, lv && !word_ready |=> lv && $stable(l_last), "lane stage dropped a stalled word")

endmodule

### rtl/core/pqadc_lane.sv
// One lane: a table bank for every sixteenth subspace and its registered read.
module pqadc_lane import pqadc_pkg::*; #(
  parameter int DEPTH = MAX_SUBSPACES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  lane_ctl_t                 ctl,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] value
);

  logic signed [VALUE_W-1:0] bank [DEPTH];
  logic signed [VALUE_W-1:0] rdata;
  logic                      use_entry;

  // Bank write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      bank[waddr] <= wdata;
    end
  end

  // Bank read port; the data holds while the lane stage is stalled.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata     <= bank[raddr];
      use_entry <= ctl.use_entry;
    end
  end

  // Subspaces past the configured count contribute nothing.
  assign value = use_entry ? rdata : '0;

endmodule

### rtl/core/pqadc_merge.sv
// Adder tree over the lanes, per-candidate accumulator and output register.
`include "pq_int4_adc_distance_assert.svh"
module pqadc_merge import pqadc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  word_ctl_t                 word,
  output logic                      word_ready,
  input  logic signed [VALUE_W-1:0] lane_val [LANES],
  pqadc_res_if.source               res
);

  localparam int GROUPS     = 4;
  localparam int GROUP_SIZE = LANES / GROUPS;
  localparam int PART_W     = VALUE_W + 2;
  localparam int WSUM_W     = PART_W + 2;

  logic signed [PART_W-1:0] parts [GROUPS];
  logic signed [PART_W-1:0] parts_next [GROUPS];
  logic                     av;
  logic                     a_last;
  logic                     a_free;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [WSUM_W-1:0] wsum_next;
  logic                     bv;
  logic                     b_last;
  logic                     b_go;
  logic                     b_free;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  acc_sum;
  logic                     out_free;

  // Handshake between stages: a stage moves when the one after it has room.
  assign out_free   = !res.valid || res.ready;
  assign b_go       = bv && (!b_last || out_free);
  assign b_free     = !bv || b_go;
  assign a_free     = !av || b_free;
  assign word_ready = a_free;

  // First tree level: four lanes per group.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      parts_next[g] = PART_W'(lane_val[g*GROUP_SIZE])
                    + PART_W'(lane_val[g*GROUP_SIZE+1])
                    + PART_W'(lane_val[g*GROUP_SIZE+2])
                    + PART_W'(lane_val[g*GROUP_SIZE+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (a_free) begin
      av <= word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && word.valid) begin
      parts  <= parts_next;
      a_last <= word.last;
    end
  end

  // Second tree level: sum of the groups.
  assign wsum_next = WSUM_W'(parts[0]) + WSUM_W'(parts[1])
                   + WSUM_W'(parts[2]) + WSUM_W'(parts[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else if (b_free) begin
      bv <= av;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && av) begin
      wsum   <= wsum_next;
      b_last <= a_last;
    end
  end

  // Accumulate the word; the last word of a candidate loads the output.
  assign acc_sum = acc + SUM_W'(wsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (b_go) begin
      acc <= b_last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (b_go && b_last) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_last) begin
      res.distance <= acc_sum;
    end
  end

  `PQADC_ASSERT(a_acc_clear, b_go && b_last |=> acc == '0, "accumulator not cleared after a candidate")
  `PQADC_ASSERT(a_tree_hold, av && !b_free |=> av && $stable(parts[0]) && $stable(parts[GROUPS-1]), "first tree stage lost a word while stalled")
  `PQADC_ASSERT(a_res_origin, $rose(res.valid) |-> $past(bv && b_last), "result without a last word")
  `PQADC_ASSERT_RST(a_rst_empty, rst |=> !res.valid && !bv && !av, "pipeline not empty after reset")

endmodule
